@@ rtl/rhsv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhsv_pkg
// Shared types and constants for the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rhsv_pkg;

  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned HUE_W    = 13;
  localparam int unsigned QUO_W    = 10;   // hue quotient reaches 960
  localparam int unsigned REM_W    = 18;   // 960*255 + 254 fits in 18 bits
  localparam int unsigned NUM_CELLS = QUO_W;

  localparam logic [HUE_W-1:0] HUE_SEXTANT = 13'd960;
  localparam logic [HUE_W-1:0] HUE_FULL    = 13'd5760;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue_out;
    logic [CHAN_W-1:0] sat_out;
    logic [CHAN_W-1:0] val_out;
  } hsv_t;

  // Everything that travels down the divider chain for one request.
  typedef struct packed {
    logic              valid;
    logic [REM_W-1:0]  hue_rem;
    logic [CHAN_W-1:0] hue_div;
    logic [QUO_W-1:0]  hue_quo;
    logic [REM_W-1:0]  sat_rem;
    logic [CHAN_W-1:0] sat_div;
    logic [QUO_W-1:0]  sat_quo;
    logic [HUE_W-1:0]  hue_base;
    logic              hue_neg;
    logic [CHAN_W-1:0] val;
  } stage_t;

endpackage

@@ rtl/rhsv_prep.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhsv_prep
// Finds max, min and chroma and forms the numerators for both divisions.
// ----------------------------------------------------------------------------
module rhsv_prep (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            req_valid,
  input  rhsv_pkg::pixel_t req_pixel,
  output rhsv_pkg::stage_t stage_o
);
  import rhsv_pkg::*;

  logic [CHAN_W-1:0] r, g, b, mx, mn, c, pos, neg, d;
  logic              red_max, green_max, is_neg;
  logic [HUE_W-1:0]  base;
  stage_t            stage_r, stage_nxt;

  always_comb begin
    r = req_pixel.red_in;
    g = req_pixel.green_in;
    b = req_pixel.blue_in;
    red_max   = (r >= g) && (r >= b);
    green_max = !red_max && (g >= b);
    mx = red_max ? r : (green_max ? g : b);
    mn = (r <= g) ? ((r <= b) ? r : b) : ((g <= b) ? g : b);
    c  = mx - mn;

    if (red_max) begin
      pos  = g;
      neg  = b;
      base = (b > g) ? HUE_FULL : '0;
    end else if (green_max) begin
      pos  = b;
      neg  = r;
      base = HUE_SEXTANT << 1;
    end else begin
      pos  = r;
      neg  = g;
      base = HUE_SEXTANT << 2;
    end
    is_neg = neg > pos;
    d      = is_neg ? (neg - pos) : (pos - neg);

    stage_nxt.valid    = req_valid;
    stage_nxt.hue_base = (c == '0) ? '0 : base;
    stage_nxt.hue_neg  = (c != '0) && is_neg;
    stage_nxt.val      = mx;
    stage_nxt.hue_quo  = '0;
    stage_nxt.sat_quo  = '0;
    // A negative offset needs the ceiling: bias the numerator by c - 1.
    if (c == '0) begin
      stage_nxt.hue_rem = '0;
      stage_nxt.hue_div = CHAN_W'(1);
    end else begin
      stage_nxt.hue_rem = REM_W'(d) * REM_W'(HUE_SEXTANT)
                        + (is_neg ? REM_W'(c - CHAN_W'(1)) : '0);
      stage_nxt.hue_div = c;
    end
    if (mx == '0) begin
      stage_nxt.sat_rem = '0;
      stage_nxt.sat_div = CHAN_W'(1);
    end else begin
      stage_nxt.sat_rem = REM_W'(c) * REM_W'(255);
      stage_nxt.sat_div = mx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
    end else begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;
endmodule

@@ rtl/rhsv_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhsv_div_cell
// One restoring-division step: settles one quotient bit of hue and saturation.
// ----------------------------------------------------------------------------
module rhsv_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rhsv_pkg::stage_t stage_i,
  output rhsv_pkg::stage_t stage_o
);
  import rhsv_pkg::*;

  logic [REM_W:0] hue_trial, sat_trial;
  stage_t         stage_r, stage_nxt;

  always_comb begin
    hue_trial = {1'b0, stage_i.hue_rem} - ((REM_W+1)'(stage_i.hue_div) << BIT);
    sat_trial = {1'b0, stage_i.sat_rem} - ((REM_W+1)'(stage_i.sat_div) << BIT);
    stage_nxt = stage_i;
    if (!hue_trial[REM_W]) begin
      stage_nxt.hue_rem      = hue_trial[REM_W-1:0];
      stage_nxt.hue_quo[BIT] = 1'b1;
    end
    if (!sat_trial[REM_W]) begin
      stage_nxt.sat_rem      = sat_trial[REM_W-1:0];
      stage_nxt.sat_quo[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
    end else begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;
endmodule

@@ rtl/rhsv_post.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhsv_post
// Applies the sextant base to the hue quotient and registers the result.
// ----------------------------------------------------------------------------
module rhsv_post (
  input  logic             clk,
  input  logic             rst_n,
  input  rhsv_pkg::stage_t stage_i,
  output logic             res_valid,
  output rhsv_pkg::hsv_t   res_data
);
  import rhsv_pkg::*;

  logic valid_r;
  hsv_t data_r, data_nxt;

  always_comb begin
    if (stage_i.hue_neg) begin
      data_nxt.hue_out = stage_i.hue_base - HUE_W'(stage_i.hue_quo);
    end else begin
      data_nxt.hue_out = stage_i.hue_base + HUE_W'(stage_i.hue_quo);
    end
    data_nxt.sat_out = stage_i.sat_quo[CHAN_W-1:0];
    data_nxt.val_out = stage_i.val;
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= stage_i.valid;
    end
  end

  assign res_valid = valid_r;
  assign res_data  = data_r;
endmodule

@@ rtl/rgb_to_hsv_conversion.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_conversion
// Fully pipelined 8-bit RGB to HSV converter.
// ----------------------------------------------------------------------------
// The block takes one pixel request in every clock cycle and never raises
// busy. Each request gives exactly one result, shown on out_data with
// out_valid high for a single cycle. A registered front stage forms max,
// min, chroma and the two numerators, a row of registered division cells,
// one per quotient bit, settles one bit of hue and saturation in each cell,
// and a final register stage adds the hue sextant base. The receiver
// cannot stall, so a result must be taken in the cycle it appears; results
// leave in request order. Hue is in sixteenths of a degree (0 to 5759),
// saturation is floor(255 * chroma / max), and value is the largest channel.
// Ties for the largest channel go to red, then green, then blue. A grey
// pixel reads hue zero, and a black pixel also reads saturation zero.
// ----------------------------------------------------------------------------
module rgb_to_hsv_conversion (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  rhsv_pkg::pixel_t in_data,
  output logic             out_valid,
  output rhsv_pkg::hsv_t   out_data
);
  import rhsv_pkg::*;

  // Chain links: link[0] leaves the front stage, link[NUM_CELLS] the last cell.
  stage_t link [NUM_CELLS+1];

  // The pipeline advances every cycle, so a request is always welcome.
  assign busy = 1'b0;

  rhsv_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (start),
    .req_pixel (in_data),
    .stage_o   (link[0])
  );

  // The first cell tests the most significant quotient bit.
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    rhsv_div_cell #(
      .BIT (NUM_CELLS - 1 - i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .stage_i (link[i]),
      .stage_o (link[i+1])
    );
  end

  rhsv_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage_i   (link[NUM_CELLS]),
    .res_valid (out_valid),
    .res_data  (out_data)
  );
endmodule

@@ rtl/rhsv_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhsv_checker
// Port-level checks for the RGB to HSV converter, bound to the top level.
// ----------------------------------------------------------------------------
module rhsv_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input rhsv_pkg::hsv_t   out_data
);
  import rhsv_pkg::*;

  localparam int unsigned LATENCY = NUM_CELLS + 2;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("request did not produce a result on time");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a matching request");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.hue_out < HUE_FULL))
    else $error("hue out of range");

  a_hue_implies_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.hue_out != '0)) |-> (out_data.sat_out != '0))
    else $error("nonzero hue with zero saturation");
endmodule

bind rgb_to_hsv_conversion rhsv_checker u_rhsv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
